[src/sdd_pkg.sv]
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared widths, constants, tables and stage types for the differential
// drive mixer.
// ----------------------------------------------------------------------------
package sdd_pkg;

    localparam int STICK_W = 11;
    localparam int CELL_W  = 16;
    localparam int XY_W    = 18;
    localparam int SQ_W    = 35;
    localparam int FS_W    = 17;
    localparam int ANG_W   = 17;
    localparam int CW      = 34;
    localparam int PRESHIFT = 12;
    localparam int ROOT_BITS = 26;
    localparam int R8_W    = 25;
    localparam int MAG_W   = 17;
    localparam int T_W     = 14;
    localparam int U_W     = 15;
    localparam int NQ_W    = 31;
    localparam int RECIP_SHIFT = 44;
    localparam int QE_W    = 2 * NQ_W - RECIP_SHIFT;
    localparam int GAIN_W  = 19;
    localparam int DUTY_FRAC = 24;

    localparam int DUTY_BITS_DEF     = 8;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [FS_W-1:0] FS_RESET = FS_W'(500);

    localparam int PI_Q      = 25736;
    localparam int HALF_PI_Q = 12868;
    localparam logic signed [ANG_W-1:0] ANG_PI   = ANG_W'(PI_Q);
    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(HALF_PI_Q);
    localparam logic [NQ_W-1:0] RECIP = NQ_W'((64'd1 << RECIP_SHIFT) / HALF_PI_Q);
    localparam logic [NQ_W-1:0] ROUND_HALF = NQ_W'(HALF_PI_Q / 2);

    localparam logic FUNC_STICK = 1'b0;
    localparam logic FUNC_CELLS = 1'b1;

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    typedef struct packed {
        logic [SQ_W-1:0]         s;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } front_t;

    typedef struct packed {
        logic [SQ_W-1:0]         s;
        logic signed [ANG_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [R8_W-1:0]         r8;
        logic signed [ANG_W-1:0] z;
    } polar_t;

    typedef struct packed {
        logic [1:0][MAG_W-1:0] ag;
        logic [1:0]            neg;
        logic [R8_W-1:0]       r8;
    } gain_t;

    function automatic logic signed [ANG_W-1:0] atan_q(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:  a = ANG_W'(6434);
            1:  a = ANG_W'(3798);
            2:  a = ANG_W'(2007);
            3:  a = ANG_W'(1019);
            4:  a = ANG_W'(511);
            5:  a = ANG_W'(256);
            6:  a = ANG_W'(128);
            7:  a = ANG_W'(64);
            8:  a = ANG_W'(32);
            9:  a = ANG_W'(16);
            10: a = ANG_W'(8);
            11: a = ANG_W'(4);
            12: a = ANG_W'(2);
            13: a = ANG_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [2:0] bp_gain(input int side, input logic [2:0] idx);
        logic signed [2:0] g;
        if (side == LEFT)
        begin
            case (idx) inside
                3'd1:       g = -3'sd1;
                3'd2, 3'd3: g = 3'sd1;
                default:    g = 3'sd0;
            endcase
        end
        else
        begin
            case (idx) inside
                3'd1:    g = -3'sd1;
                3'd2:    g = 3'sd0;
                default: g = 3'sd1;
            endcase
        end
        return g;
    endfunction

endpackage

[src/sdd_front.sv]
// ----------------------------------------------------------------------------
// sdd_front
// Forms the drive vector from the stick or the load cells, squares it and
// folds the left half plane for the angle unit.
// ----------------------------------------------------------------------------
module sdd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic signed [sdd_pkg::STICK_W-1:0]  stick_x,
    input  logic signed [sdd_pkg::STICK_W-1:0]  stick_y,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_top_left,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_top_right,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_bottom_left,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_bottom_right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sdd_pkg::front_t                     out_data
);
    import sdd_pkg::*;

    localparam int N = 3;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;
    logic [N-1:0] vsrc;

    logic [CELL_W:0] right_sum, left_sum, top_sum, bottom_sum;
    logic signed [XY_W-1:0] x_next, y_next, xa_reg, ya_reg;
    logic signed [XY_W-1:0] xf_next, yf_next, xb_reg, yb_reg;
    logic signed [ANG_W-1:0] z_next, zb_reg;
    logic signed [2*XY_W-1:0] xx_full, yy_full;
    logic [SQ_W-1:0] xx_reg, yy_reg;
    front_t c_next, c_reg;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign vsrc      = {v_reg[N-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_data  = c_reg;

    always_comb
    begin
        right_sum  = {1'b0, cell_top_right} + {1'b0, cell_bottom_right};
        left_sum   = {1'b0, cell_top_left} + {1'b0, cell_bottom_left};
        top_sum    = {1'b0, cell_top_right} + {1'b0, cell_top_left};
        bottom_sum = {1'b0, cell_bottom_right} + {1'b0, cell_bottom_left};
        if (func == FUNC_CELLS)
        begin
            x_next = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
            y_next = $signed({1'b0, top_sum}) - $signed({1'b0, bottom_sum});
        end
        else
        begin
            x_next = {{(XY_W-STICK_W){stick_x[STICK_W-1]}}, stick_x};
            y_next = {{(XY_W-STICK_W){stick_y[STICK_W-1]}}, stick_y};
        end
    end

    always_comb
    begin
        xx_full = xa_reg * xa_reg;
        yy_full = ya_reg * ya_reg;
        if (xa_reg < 0)
        begin
            xf_next = -xa_reg;
            yf_next = -ya_reg;
            z_next  = (ya_reg >= 0) ? ANG_PI : -ANG_PI;
        end
        else
        begin
            xf_next = xa_reg;
            yf_next = ya_reg;
            z_next  = '0;
        end
    end

    always_comb
    begin
        c_next.s = xx_reg + yy_reg;
        c_next.x = xb_reg;
        c_next.y = yb_reg;
        c_next.z = zb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= vsrc[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xa_reg <= x_next;
            ya_reg <= y_next;
        end
        if (en[1])
        begin
            xb_reg <= xf_next;
            yb_reg <= yf_next;
            zb_reg <= z_next;
            xx_reg <= xx_full[SQ_W-1:0];
            yy_reg <= yy_full[SQ_W-1:0];
        end
        if (en[2])
        begin
            c_reg <= c_next;
        end
    end

endmodule

[src/sdd_cordic.sv]
// ----------------------------------------------------------------------------
// sdd_cordic
// Pipelined vectoring CORDIC, one micro-rotation per stage, giving the
// Q3.13 angle clamped to plus or minus pi.
// ----------------------------------------------------------------------------
module sdd_cordic #(
    parameter int STAGES = sdd_pkg::CORDIC_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sdd_pkg::front_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sdd_pkg::vec_t   out_data
);
    import sdd_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] z;
        logic [SQ_W-1:0]         s;
    } rot_t;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vsrc;

    rot_t src [STAGES];
    rot_t st_next [STAGES];
    rot_t st_reg [STAGES];

    logic signed [CW-1:0] cx, cy, dx, dy;
    logic signed [ANG_W-1:0] cz, zl;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign vsrc      = {v_reg[STAGES-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    always_comb
    begin
        src[0].x = {{(CW-XY_W-PRESHIFT){in_data.x[XY_W-1]}}, in_data.x, {PRESHIFT{1'b0}}};
        src[0].y = {{(CW-XY_W-PRESHIFT){in_data.y[XY_W-1]}}, in_data.y, {PRESHIFT{1'b0}}};
        src[0].z = in_data.z;
        src[0].s = in_data.s;
        for (int i = 1; i < STAGES; i++)
        begin
            src[i] = st_reg[i-1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            cx = src[i].x;
            cy = src[i].y;
            cz = src[i].z;
            dx = cy >>> i;
            dy = cx >>> i;
            st_next[i].s = src[i].s;
            if (cy > 0)
            begin
                st_next[i].x = cx + dx;
                st_next[i].y = cy - dy;
                st_next[i].z = cz + atan_q(i);
            end
            else
            begin
                st_next[i].x = cx - dx;
                st_next[i].y = cy + dy;
                st_next[i].z = cz - atan_q(i);
            end
        end
    end

    always_comb
    begin
        zl = st_reg[STAGES-1].z;
        if (zl > ANG_PI)
        begin
            out_data.z = ANG_PI;
        end
        else if (zl < -ANG_PI)
        begin
            out_data.z = -ANG_PI;
        end
        else
        begin
            out_data.z = zl;
        end
        out_data.s = st_reg[STAGES-1].s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= vsrc[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

[src/sdd_root.sv]
// ----------------------------------------------------------------------------
// sdd_root
// Pipelined digit-by-digit square root of the squared length, one root bit
// per stage, then clamped to full scale.
// ----------------------------------------------------------------------------
module sdd_root (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sdd_pkg::FS_W-1:0]  fs,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sdd_pkg::vec_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sdd_pkg::polar_t           out_data
);
    import sdd_pkg::*;

    localparam int N     = ROOT_BITS;
    localparam int RAD_W = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS;

    typedef struct packed {
        logic [REM_W-1:0]        rem;
        logic [ROOT_BITS-1:0]    root;
        logic [SQ_W-1:0]         s;
        logic signed [ANG_W-1:0] z;
    } sq_t;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;
    logic [N-1:0] vsrc;

    sq_t src [N];
    sq_t st_next [N];
    sq_t st_reg [N];

    logic [RAD_W-1:0] rad;
    logic [REM_W+1:0] cur, trial;
    logic [ROOT_BITS-1:0] limit;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign vsrc      = {v_reg[N-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];

    always_comb
    begin
        src[0].rem  = '0;
        src[0].root = '0;
        src[0].s    = in_data.s;
        src[0].z    = in_data.z;
        for (int j = 1; j < N; j++)
        begin
            src[j] = st_reg[j-1];
        end
        for (int j = 0; j < N; j++)
        begin
            rad   = {{(RAD_W-SQ_W-16){1'b0}}, src[j].s, 16'b0};
            cur   = {src[j].rem, rad[RAD_W-1-2*j -: 2]};
            trial = {src[j].root, 2'b01};
            st_next[j].s = src[j].s;
            st_next[j].z = src[j].z;
            if (cur >= trial)
            begin
                st_next[j].rem  = REM_W'(cur - trial);
                st_next[j].root = {src[j].root[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                st_next[j].rem  = cur[REM_W-1:0];
                st_next[j].root = {src[j].root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        limit = {1'b0, fs, 8'b0};
        if (st_reg[N-1].root > limit)
        begin
            out_data.r8 = limit[R8_W-1:0];
        end
        else
        begin
            out_data.r8 = st_reg[N-1].root[R8_W-1:0];
        end
        out_data.z = st_reg[N-1].z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= vsrc[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

[src/sdd_gain.sv]
// ----------------------------------------------------------------------------
// sdd_gain
// Piecewise-linear left and right wheel gains over the angle, with the
// rounded division by pi/2 done as a reciprocal multiply and a correction.
// ----------------------------------------------------------------------------
module sdd_gain (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sdd_pkg::polar_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sdd_pkg::gain_t   out_data
);
    import sdd_pkg::*;

    localparam int N   = 4;
    localparam int P_W = 2 * NQ_W;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;
    logic [N-1:0] vsrc;

    logic signed [ANG_W-1:0] z, base, t_full;
    logic [1:0] k;
    logic [T_W-1:0] t;
    logic signed [2:0] g0, g1, dg;
    logic [1:0] dgm;
    logic [U_W-1:0] u;

    logic [1:0][NQ_W-1:0] n_next, n0_reg, n1_reg, n2_reg;
    logic [1:0] nq_next, nq0_reg, nq1_reg, nq2_reg;
    logic [1:0][2:0] g0_next, g00_reg, g01_reg, g02_reg;
    logic [R8_W-1:0] r80_reg, r81_reg, r82_reg;
    logic [1:0][P_W-1:0] p_next, p_reg;
    logic [1:0][QE_W-1:0] qe_next, qe_reg;
    logic [1:0][NQ_W-1:0] pc_next, pc_reg;
    logic [NQ_W-1:0] rem;
    logic [QE_W-1:0] q;
    logic signed [GAIN_W-1:0] qs, gain;
    gain_t o_next, o_reg;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign vsrc      = {v_reg[N-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_data  = o_reg;

    always_comb
    begin
        z = in_data.z;
        if (z < -ANG_HALF)
        begin
            k    = 2'd0;
            base = -ANG_PI;
        end
        else if (z < 0)
        begin
            k    = 2'd1;
            base = -ANG_HALF;
        end
        else if (z < ANG_HALF)
        begin
            k    = 2'd2;
            base = '0;
        end
        else
        begin
            k    = 2'd3;
            base = ANG_HALF;
        end
        t_full = z - base;
        t      = t_full[T_W-1:0];
        g0 = '0;
        g1 = '0;
        dg = '0;
        dgm = '0;
        u = '0;
        for (int sd = 0; sd < 2; sd++)
        begin
            g0  = bp_gain(sd, {1'b0, k});
            g1  = bp_gain(sd, 3'({1'b0, k}) + 3'd1);
            dg  = g1 - g0;
            dgm = (dg < 0) ? 2'(-dg) : 2'(dg);
            u   = (dgm[1] ? {t, 1'b0} : '0) | (dgm[0] ? {1'b0, t} : '0);
            n_next[sd]  = {u, 16'b0} + ROUND_HALF;
            nq_next[sd] = (dg < 0);
            g0_next[sd] = g0;
        end
    end

    always_comb
    begin
        for (int sd = 0; sd < 2; sd++)
        begin
            p_next[sd] = P_W'(n0_reg[sd]) * P_W'(RECIP);
        end
    end

    always_comb
    begin
        for (int sd = 0; sd < 2; sd++)
        begin
            qe_next[sd] = p_reg[sd][P_W-1:RECIP_SHIFT];
            pc_next[sd] = NQ_W'(32'(qe_next[sd]) * 32'(HALF_PI_Q));
        end
    end

    always_comb
    begin
        rem  = '0;
        q    = '0;
        qs   = '0;
        gain = '0;
        for (int sd = 0; sd < 2; sd++)
        begin
            rem  = n2_reg[sd] - pc_reg[sd];
            q    = qe_reg[sd] + QE_W'(rem >= NQ_W'(HALF_PI_Q));
            qs   = nq2_reg[sd] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            gain = $signed({g02_reg[sd], 16'b0}) + qs;
            o_next.neg[sd] = (gain < 0);
            o_next.ag[sd]  = (gain < 0) ? MAG_W'(-gain) : MAG_W'(gain);
        end
        o_next.r8 = r82_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= vsrc[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n0_reg  <= n_next;
            nq0_reg <= nq_next;
            g00_reg <= g0_next;
            r80_reg <= in_data.r8;
        end
        if (en[1])
        begin
            p_reg   <= p_next;
            n1_reg  <= n0_reg;
            nq1_reg <= nq0_reg;
            g01_reg <= g00_reg;
            r81_reg <= r80_reg;
        end
        if (en[2])
        begin
            qe_reg  <= qe_next;
            pc_reg  <= pc_next;
            n2_reg  <= n1_reg;
            nq2_reg <= nq1_reg;
            g02_reg <= g01_reg;
            r82_reg <= r81_reg;
        end
        if (en[3])
        begin
            o_reg <= o_next;
        end
    end

endmodule

[src/sdd_duty.sv]
// ----------------------------------------------------------------------------
// sdd_duty
// Scales gain times length to the duty range and divides by full scale with
// a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sdd_duty #(
    parameter int DB = sdd_pkg::DUTY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sdd_pkg::FS_W-1:0]  fs,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sdd_pkg::gain_t            in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DB-1:0]             left_fwd_duty,
    output logic [DB-1:0]             left_back_duty,
    output logic [DB-1:0]             right_fwd_duty,
    output logic [DB-1:0]             right_back_duty
);
    import sdd_pkg::*;

    localparam int N     = DB + 2;
    localparam int P_W   = MAG_W + R8_W;
    localparam int SUM_W = P_W + DB + 1;
    localparam int A_W   = SUM_W - DUTY_FRAC;

    typedef struct packed {
        logic [1:0][A_W-1:0] rem;
        logic [1:0][DB-1:0]  q;
        logic [1:0]          neg;
    } div_t;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;
    logic [N-1:0] vsrc;

    logic [1:0][P_W-1:0] p_next, p_reg;
    logic [1:0] neg0_reg;
    logic [SUM_W-1:0] sum;
    div_t a_next, a_reg;

    div_t src [DB];
    div_t st_next [DB];
    div_t st_reg [DB];
    logic [A_W-1:0] d;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign vsrc      = {v_reg[N-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];

    always_comb
    begin
        for (int sd = 0; sd < 2; sd++)
        begin
            p_next[sd] = P_W'(in_data.ag[sd]) * P_W'(in_data.r8);
        end
    end

    always_comb
    begin
        sum = '0;
        for (int sd = 0; sd < 2; sd++)
        begin
            sum = (SUM_W'(p_reg[sd]) << DB) - SUM_W'(p_reg[sd])
                + (SUM_W'(fs) << (DUTY_FRAC - 1));
            a_next.rem[sd] = sum[SUM_W-1:DUTY_FRAC];
            a_next.q[sd]   = '0;
        end
        a_next.neg = neg0_reg;
    end

    always_comb
    begin
        d = '0;
        src[0] = a_reg;
        for (int j = 1; j < DB; j++)
        begin
            src[j] = st_reg[j-1];
        end
        for (int j = 0; j < DB; j++)
        begin
            d = A_W'(fs) << (DB - 1 - j);
            st_next[j] = src[j];
            for (int sd = 0; sd < 2; sd++)
            begin
                if (src[j].rem[sd] >= d)
                begin
                    st_next[j].rem[sd] = src[j].rem[sd] - d;
                    st_next[j].q[sd][DB-1-j] = 1'b1;
                end
            end
        end
    end

    assign left_fwd_duty   = st_reg[DB-1].neg[LEFT]  ? '0 : st_reg[DB-1].q[LEFT];
    assign left_back_duty  = st_reg[DB-1].neg[LEFT]  ? st_reg[DB-1].q[LEFT] : '0;
    assign right_fwd_duty  = st_reg[DB-1].neg[RIGHT] ? '0 : st_reg[DB-1].q[RIGHT];
    assign right_back_duty = st_reg[DB-1].neg[RIGHT] ? st_reg[DB-1].q[RIGHT] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= vsrc[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg    <= p_next;
            neg0_reg <= in_data.neg;
        end
        if (en[1])
        begin
            a_reg <= a_next;
        end
        for (int j = 0; j < DB; j++)
        begin
            if (en[j+2])
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

endmodule

[src/stick_to_differential_drive.sv]
// Throughput: one item per cycle while out_ready is high; every stage advances on its own
// valid/ready, so bubbles close up and a stalled result does not stop earlier stages filling.
// The depth is set by the CORDIC stages, the 26 root bit stages and the divider bits.
// Reset clears all valid bits and loads full_scale with 500; no clearing pass.
// ----------------------------------------------------------------------------
// stick_to_differential_drive
// Maps a stick or balance-board sample to the forward and backward PWM duties
// of a two-wheel differential drive.
// ----------------------------------------------------------------------------
module stick_to_differential_drive #(
    parameter int DUTY_BITS     = sdd_pkg::DUTY_BITS_DEF,
    parameter int CORDIC_STAGES = sdd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdd_pkg::FS_W-1:0]            cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic signed [sdd_pkg::STICK_W-1:0]  stick_x,
    input  logic signed [sdd_pkg::STICK_W-1:0]  stick_y,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_top_left,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_top_right,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_bottom_left,
    input  logic [sdd_pkg::CELL_W-1:0]          cell_bottom_right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [DUTY_BITS-1:0]                left_fwd_duty,
    output logic [DUTY_BITS-1:0]                left_back_duty,
    output logic [DUTY_BITS-1:0]                right_fwd_duty,
    output logic [DUTY_BITS-1:0]                right_back_duty
);
    import sdd_pkg::*;

    logic [FS_W-1:0] full_scale_reg;
    logic [FS_W-1:0] fs;

    logic   f_valid, f_ready;
    front_t f_data;
    logic   c_valid, c_ready;
    vec_t   c_data;
    logic   r_valid, r_ready;
    polar_t r_data;
    logic   g_valid, g_ready;
    gain_t  g_data;

    assign cfg_ready = 1'b1;
    assign fs = (full_scale_reg == '0) ? FS_W'(1) : full_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            full_scale_reg <= cfg_data;
        end
    end

    sdd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .stick_x           (stick_x),
        .stick_y           (stick_y),
        .cell_top_left     (cell_top_left),
        .cell_top_right    (cell_top_right),
        .cell_bottom_left  (cell_bottom_left),
        .cell_bottom_right (cell_bottom_right),
        .out_valid         (f_valid),
        .out_ready         (f_ready),
        .out_data          (f_data)
    );

    sdd_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    sdd_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .fs        (fs),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    sdd_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_data   (r_data),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .out_data  (g_data)
    );

    sdd_duty #(
        .DB (DUTY_BITS)
    ) u_duty (
        .clk             (clk),
        .rst_n           (rst_n),
        .fs              (fs),
        .in_valid        (g_valid),
        .in_ready        (g_ready),
        .in_data         (g_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_fwd_duty   (left_fwd_duty),
        .left_back_duty  (left_back_duty),
        .right_fwd_duty  (right_fwd_duty),
        .right_back_duty (right_back_duty)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Differential drive mixer testbench
// Drives stick and load-cell items into the mixer under random idling on both sides
// (but for the last random run) and compares every result with duties computed here in fixed point.
// ----------------------------------------------------------------------------
module tb;
    import sdd_pkg::*;

    localparam int DUTY_MAX = 255;

    typedef struct {
        logic [7:0] lf;
        logic [7:0] lb;
        logic [7:0] rf;
        logic [7:0] rb;
    } duties_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [FS_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = 1'b0;
    logic signed [STICK_W-1:0] stick_x = '0;
    logic signed [STICK_W-1:0] stick_y = '0;
    logic [CELL_W-1:0] cell_top_left = '0;
    logic [CELL_W-1:0] cell_top_right = '0;
    logic [CELL_W-1:0] cell_bottom_left = '0;
    logic [CELL_W-1:0] cell_bottom_right = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] left_fwd_duty;
    logic [7:0] left_back_duty;
    logic [7:0] right_fwd_duty;
    logic [7:0] right_back_duty;

    duties_t expected_duties[$];
    longint full_scale_reg = 500;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int out_idle_left = 0;
    bit idle_enable = 1'b1;

    stick_to_differential_drive dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .stick_x(stick_x), .stick_y(stick_y),
        .cell_top_left(cell_top_left), .cell_top_right(cell_top_right),
        .cell_bottom_left(cell_bottom_left), .cell_bottom_right(cell_bottom_right),
        .out_valid(out_valid), .out_ready(out_ready),
        .left_fwd_duty(left_fwd_duty), .left_back_duty(left_back_duty),
        .right_fwd_duty(right_fwd_duty), .right_back_duty(right_back_duty)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding.", expected_duties.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        x = x * 4096;
        y = y * 4096;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q(i));
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q(i));
            end
        end
        if (z > PI_Q)
            z = PI_Q;
        if (z < -PI_Q)
            z = -PI_Q;
        return z;
    endfunction

    function automatic longint wheel_gain(longint a, bit right_side);
        longint bps[5];
        longint gl[5];
        longint gr[5];
        longint g0;
        longint g1;
        longint num;
        longint q;
        int k;
        bps = '{-PI_Q, -HALF_PI_Q, 0, HALF_PI_Q, PI_Q};
        gl = '{0, -1, 1, 1, 0};
        gr = '{1, -1, 0, 1, 1};
        if (a < bps[1])
            k = 0;
        else if (a < bps[2])
            k = 1;
        else if (a < bps[3])
            k = 2;
        else
            k = 3;
        g0 = right_side ? gr[k] : gl[k];
        g1 = right_side ? gr[k + 1] : gl[k + 1];
        num = (a - bps[k]) * (g1 - g0) * 65536;
        if (num >= 0)
            q = (num + HALF_PI_Q / 2) / HALF_PI_Q;
        else
            q = -((-num + HALF_PI_Q / 2) / HALF_PI_Q);
        return g0 * 65536 + q;
    endfunction

    function automatic logic [7:0] pin_duty(longint gain, longint r8, longint fs);
        longint ag;
        longint den;
        ag = gain < 0 ? -gain : gain;
        den = fs << 24;
        return 8'((ag * r8 * DUTY_MAX + den / 2) / den);
    endfunction

    function automatic duties_t predict_duties(logic f, logic signed [10:0] sx,
                                               logic signed [10:0] sy,
                                               logic [15:0] tl, logic [15:0] tr,
                                               logic [15:0] bl, logic [15:0] br);
        longint x;
        longint y;
        longint fs;
        longint r8;
        longint ang;
        longint gl;
        longint gr;
        duties_t d;
        fs = (full_scale_reg == 0) ? 1 : full_scale_reg;
        if (f == FUNC_CELLS)
        begin
            x = (longint'(tr) + br) - (longint'(tl) + bl);
            y = (longint'(tr) + tl) - (longint'(br) + bl);
        end
        else
        begin
            x = sx;
            y = sy;
        end
        r8 = int_sqrt((x * x + y * y) << 16);
        if (r8 > (fs << 8))
            r8 = fs << 8;
        ang = vector_angle(x, y);
        gl = wheel_gain(ang, 1'b0);
        gr = wheel_gain(ang, 1'b1);
        d.lf = gl < 0 ? 8'd0 : pin_duty(gl, r8, fs);
        d.lb = gl < 0 ? pin_duty(gl, r8, fs) : 8'd0;
        d.rf = gr < 0 ? 8'd0 : pin_duty(gr, r8, fs);
        d.rb = gr < 0 ? pin_duty(gr, r8, fs) : 8'd0;
        return d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("Mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_duties.size() == 0)
                begin
                    errors++;
                    $display("Unexpected result at %0t", $realtime);
                end
                else
                begin
                    duties_t e;
                    e = expected_duties.pop_front();
                    if (left_fwd_duty !== e.lf)
                        report_mismatch("left_fwd_duty", left_fwd_duty, e.lf);
                    if (left_back_duty !== e.lb)
                        report_mismatch("left_back_duty", left_back_duty, e.lb);
                    if (right_fwd_duty !== e.rf)
                        report_mismatch("right_fwd_duty", right_fwd_duty, e.rf);
                    if (right_back_duty !== e.rb)
                        report_mismatch("right_back_duty", right_back_duty, e.rb);
                end
                results_seen++;
            end
            if (idle_enable && out_idle_left == 0 && $urandom_range(0, 5) == 0)
                out_idle_left = $urandom_range(1, 8);
            if (out_idle_left > 0)
            begin
                out_idle_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic f, logic signed [10:0] sx, logic signed [10:0] sy,
                             logic [15:0] tl, logic [15:0] tr,
                             logic [15:0] bl, logic [15:0] br);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        stick_x <= sx;
        stick_y <= sy;
        cell_top_left <= tl;
        cell_top_right <= tr;
        cell_bottom_left <= bl;
        cell_bottom_right <= br;
        expected_duties.push_back(predict_duties(f, sx, sy, tl, tr, bl, br));
        items_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_stick(int sx, int sy);
        send_item(FUNC_STICK, 11'(sx), 11'(sy), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic send_cells(int tl, int tr, int bl, int br);
        send_item(FUNC_CELLS, 11'($urandom), 11'($urandom), 16'(tl), 16'(tr),
                  16'(bl), 16'(br));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_duties.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_full_scale(longint v);
        cfg_valid <= 1'b1;
        cfg_data <= FS_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        full_scale_reg = v;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_stick(0, 0);
        send_stick(512, 0);
        send_stick(-512, 0);
        send_stick(0, 512);
        send_stick(0, -512);
        send_stick(-512, -1);
        send_stick(-512, 1);
        send_stick(512, 512);
        send_stick(-512, 512);
        send_stick(-512, -512);
        send_stick(512, -512);
        send_stick(-1024, -1024);
        send_stick(1023, 1023);
        send_stick(-1, 0);
        send_cells(0, 0, 0, 0);
        send_cells(65535, 65535, 65535, 65535);
        send_cells(0, 65535, 0, 65535);
        send_cells(65535, 0, 65535, 0);
        send_cells(65535, 65535, 0, 0);
        send_cells(0, 0, 65535, 65535);
        send_cells(0, 65535, 65535, 0);
        send_cells(65535, 0, 0, 65535);
        drain();
    endtask

    task automatic test_random(int count, bit idle);
        idle_enable = idle;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: send_stick($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512);
                1: send_item(FUNC_STICK, 11'($urandom), 11'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
                2: send_cells($urandom_range(0, 2000), $urandom_range(0, 2000),
                              $urandom_range(0, 2000), $urandom_range(0, 2000));
                default: send_cells($urandom, $urandom, $urandom, $urandom);
            endcase
        end
        drain();
    endtask

    task automatic test_full_scale_sweep();
        longint settings[6];
        settings = '{0, 1, 131071, 700, 65536, 37};
        foreach (settings[i])
        begin
            write_full_scale(settings[i]);
            test_random(60, 1'b1);
        end
        write_full_scale(500);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 1'b1);
        test_full_scale_sweep();
        test_random(370, 1'b0);
        $display("Sent %0d items, checked %0d results over seven full-scale settings.",
                 items_sent, results_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
